[hdl/zcpt_pkg.sv]
`timescale 1ns / 1ps

package zcpt_pkg;

    // Field and register widths
    localparam int WORD_W      = 16;
    localparam int COUNT_W     = 7;
    localparam int SELECT_W    = 6;
    localparam int STEP_W      = 32;
    localparam int ACC_W       = 64;
    localparam int FRAC_W      = 16;
    localparam int TIME_W      = 48;
    localparam int INDEX_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    localparam int MAX_CHANNELS = 64;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset values of the registers
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(1);
    localparam logic [SELECT_W-1:0] SELECT_RESET = '0;
    localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(2048000);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHANNEL_COUNT  = 2'd0,
        REG_CHANNEL_SELECT = 2'd1,
        REG_TIME_STEP      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  channel_count;
        logic [SELECT_W-1:0] channel_select;
        logic [STEP_W-1:0]   time_per_sample_q16;
    } cfg_t;

    // One kept sample as handed from front to back
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [INDEX_W-1:0]       index;
        logic [TIME_W-1:0]        stamp;
    } sample_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hdl/zcpt_in_if.sv]
`timescale 1ns / 1ps

interface zcpt_in_if;
    import zcpt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

[hdl/zcpt_out_if.sv]
`timescale 1ns / 1ps

interface zcpt_out_if;
    import zcpt_pkg::*;

    logic               valid;
    logic               ready;
    logic               level_on;
    logic [TIME_W-1:0]  event_time;
    logic [INDEX_W-1:0] frame_index;

    modport source (output valid, output level_on, output event_time, output frame_index,
                    input ready);
    modport sink   (input valid, input level_on, input event_time, input frame_index,
                    output ready);
endinterface

[hdl/zcpt_front.sv]
`timescale 1ns / 1ps

module zcpt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  zcpt_pkg::cfg_t      cfg,
    zcpt_in_if.sink             samples,
    input  zcpt_pkg::q_status_t q_status,
    output logic                push,
    output zcpt_pkg::sample_t   push_data
);
    import zcpt_pkg::*;

    logic [SELECT_W-1:0] slot_reg, slot_next;
    logic [INDEX_W-1:0]  count_reg, count_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [COUNT_W-1:0]  n_eff;
    logic [COUNT_W-1:0]  slot_plus;
    logic                accept;
    logic                selected;

    // channel count zero acts as one, above the maximum it saturates
    always_comb
    begin
        if (cfg.channel_count == '0)
            n_eff = COUNT_W'(1);
        else if (cfg.channel_count > COUNT_W'(MAX_CHANNELS))
            n_eff = COUNT_W'(MAX_CHANNELS);
        else
            n_eff = cfg.channel_count;
    end

    assign samples.ready = !q_status.full;
    assign accept        = samples.valid && samples.ready;
    assign slot_plus     = {1'b0, slot_reg} + COUNT_W'(1);
    assign selected      = (slot_reg == cfg.channel_select);
    assign push          = accept && selected;

    assign push_data.value = samples.word;
    assign push_data.index = count_reg;
    assign push_data.stamp = acc_reg[FRAC_W +: TIME_W];

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        if (accept)
        begin
            slot_next = (slot_plus >= n_eff) ? '0 : slot_plus[SELECT_W-1:0];
            if (selected)
            begin
                count_next = count_reg + INDEX_W'(1);
                acc_next   = acc_reg + ACC_W'(cfg.time_per_sample_q16);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            count_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

[hdl/zcpt_queue.sv]
`timescale 1ns / 1ps

module zcpt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  zcpt_pkg::sample_t   push_data,
    input  logic                pop,
    output zcpt_pkg::sample_t   pop_data,
    output zcpt_pkg::q_status_t status
);
    import zcpt_pkg::*;

    sample_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hdl/zcpt_back.sv]
`timescale 1ns / 1ps

module zcpt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  zcpt_pkg::q_status_t q_status,
    input  zcpt_pkg::sample_t   pop_data,
    output logic                pop,
    zcpt_out_if.source          events
);
    import zcpt_pkg::*;

    logic                     have_prev_reg, have_prev_next;
    logic                     crossing_reg, crossing_next;
    logic signed [WORD_W-1:0] prev_value_reg, prev_value_next;
    logic [TIME_W-1:0]        prev_time_reg, prev_time_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     level_reg, level_next;
    logic [TIME_W-1:0]        time_reg, time_next;
    logic [INDEX_W-1:0]       index_reg, index_next;

    logic signed [WORD_W-1:0] p;
    logic signed [WORD_W-1:0] v;
    logic                     is_cross;
    logic                     is_turn;
    logic                     emit;

    assign p = prev_value_reg;
    assign v = pop_data.value;

    // take a sample only when the result register is free or being drained
    assign pop = !q_status.empty && (!out_valid_reg || events.ready);

    assign is_cross = ((p <= 0) && (v > 0)) || ((p >= 0) && (v < 0));
    assign is_turn  = ((p > 0) && (p > v)) || ((p < 0) && (p < v));
    assign emit     = pop && have_prev_reg && crossing_reg && is_turn;

    always_comb
    begin
        have_prev_next  = have_prev_reg;
        crossing_next   = crossing_reg;
        prev_value_next = prev_value_reg;
        prev_time_next  = prev_time_reg;
        if (pop)
        begin
            if (have_prev_reg)
            begin
                // the arming sample gets no peak test
                if (!crossing_reg)
                    crossing_next = is_cross;
                else if (is_turn)
                    crossing_next = 1'b0;
            end
            have_prev_next  = 1'b1;
            prev_value_next = v;
            prev_time_next  = pop_data.stamp;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        time_next      = time_reg;
        index_next     = index_reg;
        if (pop)
            out_valid_next = emit;
        else if (events.ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            level_next = (p > 0);
            time_next  = prev_time_reg;
            index_next = pop_data.index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            crossing_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            crossing_reg  <= crossing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_value_reg <= prev_value_next;
        prev_time_reg  <= prev_time_next;
        level_reg      <= level_next;
        time_reg       <= time_next;
        index_reg      <= index_next;
    end

    assign events.valid       = out_valid_reg;
    assign events.level_on    = level_reg;
    assign events.event_time  = time_reg;
    assign events.frame_index = index_reg;

endmodule

[hdl/zero_cross_peak_transition_detector.sv]
`timescale 1ns / 1ps

// Zero-crossing / peak transition detector. Interleaved signed 16-bit words
// arrive on the samples channel, one item per clock while samples.ready is
// high; only the word at slot channel_select of each channel_count-word frame
// is kept. After a sign crossing arms the detector, the first sample that
// turns back toward zero produces one item on the events channel carrying the
// peak's polarity, its timestamp (integer part of the running Q16 time sum)
// and the index of the sample after the peak. Sustained rate is one word per
// cycle while the events sink keeps up: the front end filters and timestamps
// each word as it is accepted, a 4-entry queue holds kept samples, and the
// back end pops one per cycle into a single output register unless a result
// in it waits untaken. An accepted word is queued, then its result registered.
// samples.ready drops only when the queue is full, i.e. when the events sink
// has held off for four queued kept samples. No clearing pass after reset.
// Register writes (cfg_we/cfg_index/cfg_data) take effect on the next word
// and are meant to be done while the block is idle.
module zero_cross_peak_transition_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [zcpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [zcpt_pkg::CFG_DATA_W-1:0]  cfg_data,
    zcpt_in_if.sink                          samples,
    zcpt_out_if.source                       events
);
    import zcpt_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_status;
    sample_t   push_data;
    sample_t   pop_data;
    logic      push;
    logic      pop;

    // Register file: unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CHANNEL_COUNT:  cfg_next.channel_count       = cfg_data[COUNT_W-1:0];
                REG_CHANNEL_SELECT: cfg_next.channel_select      = cfg_data[SELECT_W-1:0];
                REG_TIME_STEP:      cfg_next.time_per_sample_q16 = cfg_data[STEP_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count       <= COUNT_RESET;
            cfg_reg.channel_select      <= SELECT_RESET;
            cfg_reg.time_per_sample_q16 <= STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: slot filter, sample index and time accumulator
    zcpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .samples   (samples),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Decoupling queue of kept samples
    zcpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Back end: crossing/peak detection and the output register
    zcpt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .events   (events)
    );

endmodule

[hdl/zcpt_checker.sv]
`timescale 1ns / 1ps

module zcpt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             out_level_on,
    input logic [zcpt_pkg::TIME_W-1:0]      out_event_time,
    input logic [zcpt_pkg::INDEX_W-1:0]     out_frame_index
);
    import zcpt_pkg::*;

    // a pending result stays up until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_level_on) && $stable(out_event_time)
                                    && $stable(out_frame_index))
        else $error("result payload changed while stalled");

    // reset leaves no result pending
    assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result pending right after reset");

    // queue is empty after reset, so the input side is open
    assert property (@(posedge clk)
        !$past(rst_n) && rst_n |-> in_ready)
        else $error("input not ready right after reset");

endmodule

bind zero_cross_peak_transition_detector zcpt_checker u_zcpt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (samples.ready),
    .out_valid       (events.valid),
    .out_ready       (events.ready),
    .out_level_on    (events.level_on),
    .out_event_time  (events.event_time),
    .out_frame_index (events.frame_index)
);
